FILE: src/epsc_pkg.sv
// ----------------------------------------------------------------------------
// epsc_pkg: shared types and constants of the expiring partition share counter
// Holds the sizes, the op codes and the item types of both channels.
// ----------------------------------------------------------------------------
`default_nettype none
package epsc_pkg;
	localparam int PARTITIONS   = 256;
	localparam int EXPIRY_DEPTH = 64;
	localparam int PW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
	localparam int EW = $clog2(EXPIRY_DEPTH);
	localparam int OW = EW + 1;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_INCR  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  partition;
		logic [15:0] step;
		logic [30:0] ttl_ticks;
	} in_item_t;

	typedef struct packed {
		logic [15:0] percent;
		logic        total_empty;
		logic        store_full;
	} out_item_t;
endpackage
`default_nettype wire

FILE: src/epsc_in_if.sv
// ----------------------------------------------------------------------------
// epsc_in_if: input channel
// Valid/ready channel that carries one input item.
// ----------------------------------------------------------------------------
`default_nettype none
interface epsc_in_if import epsc_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/epsc_out_if.sv
// ----------------------------------------------------------------------------
// epsc_out_if: output channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
`default_nettype none
interface epsc_out_if import epsc_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/expiring_partition_share_counter_top.sv
// ----------------------------------------------------------------------------
// expiring_partition_share_counter_top: per-partition counter with expiry
// Counts, expires timed increments and reports a partition's share in percent.
// ----------------------------------------------------------------------------
// One item at a time. A clearing pass over the partition counts follows reset
// before the first item is taken. An increment adds its step to the count. A tick
// or a query first sweeps the expiry store, moving the last entry into the place
// of each one removed; a query on a nonzero total then runs a 23-step
// restoring division, one quotient bit a cycle. One result follows each item
// and is held in an output register until taken; the next item is taken only
// once that result has gone.
`default_nettype none
module expiring_partition_share_counter_top import epsc_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	epsc_in_if.sink   in_ch,
	epsc_out_if.source out_ch
);
	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_DEC   = 5'd2;
	localparam logic [4:0] S_IRD   = 5'd3;
	localparam logic [4:0] S_IWR   = 5'd4;
	localparam logic [4:0] S_SRD   = 5'd5;
	localparam logic [4:0] S_SWT   = 5'd6;
	localparam logic [4:0] S_SCHK  = 5'd7;
	localparam logic [4:0] S_SPW   = 5'd8;
	localparam logic [4:0] S_SPWR  = 5'd9;
	localparam logic [4:0] S_SLRD  = 5'd10;
	localparam logic [4:0] S_SLWT  = 5'd11;
	localparam logic [4:0] S_SLWR  = 5'd12;
	localparam logic [4:0] S_SEND  = 5'd13;
	localparam logic [4:0] S_QRD   = 5'd14;
	localparam logic [4:0] S_QWT   = 5'd15;
	localparam logic [4:0] S_QMUL  = 5'd16;
	localparam logic [4:0] S_DIV   = 5'd17;
	localparam logic [4:0] S_OUT   = 5'd18;
	localparam int         EWD     = 32 + 8 + 16;
	localparam int         DIVN    = 23;

	logic [4:0]        state_q;
	logic [PW:0]       clr_q;
	in_item_t          item_q;
	logic [15:0]       total_q;
	logic [31:0]       time_q;
	logic [OW-1:0]     occ_q;
	logic [EW-1:0]     idx_q;
	logic [EWD-1:0]    ent_q;
	logic [15:0]       cnt_q;
	logic [22:0]       num_q;
	logic [16:0]       rem_q;
	logic [22:0]       quo_q;
	logic [4:0]        dcnt_q;
	logic              ovalid_q;
	out_item_t         odata_q;

	logic              pwe;
	logic [PW-1:0]     paddr;
	logic [15:0]       pwdata;
	logic [15:0]       prdata;
	logic              ewe;
	logic [EW-1:0]     eaddr;
	logic [EWD-1:0]    ewdata;
	logic [EWD-1:0]    erdata;
	logic              part_ok;
	logic [16:0]       rem_sh;
	logic [17:0]       rem_sub;

	assign part_ok = ({1'b0, item_q.partition} < 9'(PARTITIONS));
	assign rem_sh  = {rem_q[15:0], num_q[22]};
	assign rem_sub = {1'b0, rem_sh} - {2'b00, total_q};

	epsc_ram #(.WIDTH(16), .DEPTH(PARTITIONS)) u_cnt_ram (
		.clk(clk), .we(pwe), .addr(paddr), .wdata(pwdata), .rdata(prdata));
	epsc_ram #(.WIDTH(EWD), .DEPTH(EXPIRY_DEPTH)) u_exp_ram (
		.clk(clk), .we(ewe), .addr(eaddr), .wdata(ewdata), .rdata(erdata));

	always_comb begin
		pwe    = 1'b0;
		paddr  = item_q.partition[PW-1:0];
		pwdata = cnt_q;
		ewe    = 1'b0;
		eaddr  = idx_q;
		ewdata = ent_q;
		unique case (state_q)
			S_CLR: begin
				pwe    = 1'b1;
				paddr  = clr_q[PW-1:0];
				pwdata = '0;
			end
			S_IWR: begin
				pwe    = 1'b1;
				pwdata = prdata + item_q.step;
				ewe    = (item_q.ttl_ticks != '0);
				eaddr  = occ_q[EW-1:0];
				ewdata = {time_q + {1'b0, item_q.ttl_ticks}, item_q.partition,
					item_q.step};
			end
			S_SPW, S_SPWR: begin
				paddr = ent_q[23:16];
				pwe   = (state_q == S_SPWR);
				pwdata = prdata - ent_q[15:0];
			end
			S_SLRD: eaddr = occ_q[EW-1:0];
			S_SLWR: ewe = 1'b1;
			default: ;
		endcase
	end

	assign in_ch.ready   = (state_q == S_IDLE) && !ovalid_q;
	assign out_ch.valid  = ovalid_q;
	assign out_ch.data   = odata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			total_q  <= '0;
			time_q   <= '0;
			occ_q    <= '0;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
			dcnt_q   <= '0;
		end else begin
			if (ovalid_q && out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (PW+1)'(PARTITIONS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_ch.valid && !ovalid_q) begin
						item_q  <= in_ch.data;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					odata_q <= '0;
					idx_q   <= '0;
					priority case (item_q.op)
						OP_TICK, OP_QUERY: state_q <= S_SRD;
						OP_INCR: begin
							if (!part_ok) begin
								state_q <= S_OUT;
							end else if (item_q.ttl_ticks != '0 &&
									occ_q == OW'(EXPIRY_DEPTH)) begin
								odata_q.store_full <= 1'b1;
								state_q <= S_OUT;
							end else begin
								state_q <= S_IRD;
							end
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_IRD: state_q <= S_IWR;
				S_IWR: begin
					total_q <= total_q + item_q.step;
					if (item_q.ttl_ticks != '0) begin
						occ_q <= occ_q + 1'b1;
					end
					state_q <= S_OUT;
				end
				S_SRD: begin
					state_q <= ({1'b0, idx_q} < occ_q) ? S_SWT : S_SEND;
				end
				S_SWT: state_q <= S_SCHK;
				S_SCHK: begin
					ent_q <= erdata;
					if (((time_q - erdata[55:24]) & 32'h8000_0000) == '0) begin
						state_q <= S_SPW;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ({1'b0, idx_q} == occ_q - 1'b1) ? S_SEND : S_SRD;
					end
				end
				S_SPW: state_q <= S_SPWR;
				S_SPWR: begin
					total_q <= total_q - ent_q[15:0];
					occ_q   <= occ_q - 1'b1;
					state_q <= S_SLRD;
				end
				S_SLRD: state_q <= S_SLWT;
				S_SLWT: begin
					ent_q   <= erdata;
					state_q <= S_SLWR;
				end
				S_SLWR: state_q <= S_SRD;
				S_SEND: begin
					if (item_q.op == OP_TICK) begin
						time_q  <= time_q + 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_QRD;
					end
				end
				S_QRD: state_q <= S_QWT;
				S_QWT: begin
					cnt_q   <= prdata;
					state_q <= S_QMUL;
				end
				S_QMUL: begin
					num_q   <= {7'd0, cnt_q} * 23'd100;
					rem_q   <= '0;
					quo_q   <= '0;
					dcnt_q  <= '0;
					state_q <= (part_ok && total_q != '0) ? S_DIV : S_OUT;
				end
				S_DIV: begin
					num_q <= {num_q[21:0], 1'b0};
					if (!rem_sub[17]) begin
						rem_q <= rem_sub[16:0];
						quo_q <= {quo_q[21:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[21:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 5'(DIVN - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!ovalid_q) begin
						if (item_q.op == OP_QUERY && dcnt_q == 5'(DIVN)) begin
							odata_q.percent <= (quo_q[22:16] != '0) ? 16'hFFFF : quo_q[15:0];
						end
						odata_q.total_empty <= (total_q == '0);
						ovalid_q <= 1'b1;
						dcnt_q   <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(EXPIRY_DEPTH))
		else $error("expiry occupancy above depth");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> (state_q == S_IDLE))
		else $error("ready outside idle");
	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.store_full) |-> (occ_q == OW'(EXPIRY_DEPTH)))
		else $error("store full flagged with room left");
	a_time_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_SEND) |=> $stable(time_q))
		else $error("time moved outside a tick");
endmodule
`default_nettype wire

FILE: src/epsc_ram.sv
// ----------------------------------------------------------------------------
// epsc_ram: generic single-port RAM
// One access a cycle: a write if enabled, and a registered read of the old word.
// ----------------------------------------------------------------------------
`default_nettype none
module epsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the expiring partition share counter
// Drives ticks, increments and queries through the input channel with random
// gaps, predicts every result from its own model of counts, total, time and
// expiry store, and compares each result taken from the output channel.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
	import epsc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;

	epsc_in_if  in_ch();
	epsc_out_if out_ch();

	expiring_partition_share_counter_top dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	// predictor state
	logic [15:0] part_count [PARTITIONS];
	logic [15:0] total;
	logic [31:0] now;
	logic [31:0] exp_at   [EXPIRY_DEPTH];
	logic [7:0]  exp_part [EXPIRY_DEPTH];
	logic [15:0] exp_step [EXPIRY_DEPTH];
	int          held;

	in_item_t  pending_items [$];
	out_item_t expected_results [$];
	int        errors;
	bit        stim_done;
	bit        quiet_in, quiet_out;
	int        idle_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic remove_expired();
		int i;
		i = 0;
		while (i < held) begin
			if (((now - exp_at[i]) & 32'h8000_0000) == 0) begin
				part_count[exp_part[i]] = part_count[exp_part[i]] - exp_step[i];
				total = total - exp_step[i];
				held--;
				exp_at[i]   = exp_at[held];
				exp_part[i] = exp_part[held];
				exp_step[i] = exp_step[held];
			end else begin
				i++;
			end
		end
	endtask

	task automatic predict_share(input in_item_t it);
		out_item_t r;
		logic [31:0] q;
		r = '0;
		case (it.op)
			OP_TICK: begin
				remove_expired();
				now = now + 1;
			end
			OP_INCR: begin
				if (it.ttl_ticks != 0 && held >= EXPIRY_DEPTH) begin
					r.store_full = 1'b1;
				end else begin
					part_count[it.partition] = part_count[it.partition] + it.step;
					total = total + it.step;
					if (it.ttl_ticks != 0) begin
						exp_at[held]   = now + {1'b0, it.ttl_ticks};
						exp_part[held] = it.partition;
						exp_step[held] = it.step;
						held++;
					end
				end
			end
			OP_QUERY: begin
				remove_expired();
				if (total != 0) begin
					q = (32'd100 * part_count[it.partition]) / total;
					r.percent = (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
				end
			end
			default: ;
		endcase
		r.total_empty = (total == 0);
		expected_results.push_back(r);
	endtask

	function automatic in_item_t mk(input logic [1:0] op, input logic [7:0] p,
			input logic [15:0] s, input logic [30:0] t);
		in_item_t it;
		it.op = op; it.partition = p; it.step = s; it.ttl_ticks = t;
		return it;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int k;
		it.partition = $urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(0, 5));
		k = $urandom_range(0, 19);
		it.step = k < 2 ? 16'($urandom) : (k == 2 ? 16'hFFFF : 16'($urandom_range(0, 300)));
		k = $urandom_range(0, 19);
		it.ttl_ticks = k < 6 ? '0 : (k < 18 ? 31'($urandom_range(1, 12)) : 31'($urandom));
		k = $urandom_range(0, 99);
		it.op = k < 30 ? OP_TICK : (k < 70 ? OP_INCR : (k < 98 ? OP_QUERY : 2'd3));
		return it;
	endfunction

	initial begin
		int n;
		arst_n = 1'b0;
		errors = 0;
		stim_done = 1'b0;
		total = '0; now = '0; held = 0;
		foreach (part_count[i]) part_count[i] = '0;
		// directed: empty query, extremes, wrap, unused op, expiry
		pending_items.push_back(mk(OP_QUERY, 8'd0, 16'd0, 31'd0));
		pending_items.push_back(mk(OP_INCR, 8'd255, 16'hFFFF, 31'd0));
		pending_items.push_back(mk(OP_QUERY, 8'd255, 16'd0, 31'd0));
		pending_items.push_back(mk(OP_INCR, 8'd0, 16'd1, 31'd0));
		pending_items.push_back(mk(OP_QUERY, 8'd255, 16'd0, 31'd0));
		pending_items.push_back(mk(OP_QUERY, 8'd0, 16'd0, 31'd0));
		pending_items.push_back(mk(OP_INCR, 8'd3, 16'd40, 31'd1));
		pending_items.push_back(mk(OP_INCR, 8'd4, 16'd60, 31'h7FFF_FFFF));
		pending_items.push_back(mk(OP_QUERY, 8'd3, 16'd0, 31'd0));
		pending_items.push_back(mk(OP_TICK, 8'd0, 16'd0, 31'd0));
		pending_items.push_back(mk(OP_TICK, 8'd0, 16'd0, 31'd0));
		pending_items.push_back(mk(OP_QUERY, 8'd3, 16'd0, 31'd0));
		pending_items.push_back(mk(2'd3, 8'hFF, 16'hFFFF, 31'h7FFF_FFFF));
		pending_items.push_back(mk(OP_INCR, 8'd7, 16'd0, 31'd0));
		pending_items.push_back(mk(OP_QUERY, 8'd4, 16'd0, 31'd0));
		// fill the store, then three refused increments
		for (int i = 0; i < EXPIRY_DEPTH + 2; i++)
			pending_items.push_back(mk(OP_INCR, 8'(i), 16'(i + 1), 31'd3));
		pending_items.push_back(mk(OP_QUERY, 8'd5, 16'd0, 31'd0));
		for (int i = 0; i < 4; i++) pending_items.push_back(mk(OP_TICK, 8'd0, 16'd0, 31'd0));
		pending_items.push_back(mk(OP_QUERY, 8'd5, 16'd0, 31'd0));
		n = 0;
		while (n < 750) begin
			pending_items.push_back(random_item());
			n++;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data  <= '0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid) predict_share(in_ch.data);
			if (pending_items.size() != 0 && (quiet_in || $urandom_range(0, 99) >= 31)) begin
				in_ch.valid <= 1'b1;
				in_ch.data  <= pending_items.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
				if (pending_items.size() == 0) stim_done <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result with nothing expected");
					errors++;
				end else begin
					out_item_t e;
					e = expected_results.pop_front();
					if (out_ch.data.percent !== e.percent) begin
						$error("percent: expected %0d got %0d", e.percent, out_ch.data.percent);
						errors++;
					end
					if (out_ch.data.total_empty !== e.total_empty) begin
						$error("total_empty: expected %0d got %0d", e.total_empty,
							out_ch.data.total_empty);
						errors++;
					end
					if (out_ch.data.store_full !== e.store_full) begin
						$error("store_full: expected %0d got %0d", e.store_full,
							out_ch.data.store_full);
						errors++;
					end
				end
			end
			out_ch.ready <= quiet_out || $urandom_range(0, 99) >= 31;
		end
	end

	// no-idling stretch part way through
	always @(posedge clk) begin
		quiet_in  <= pending_items.size() > 300 && pending_items.size() < 450;
		quiet_out <= pending_items.size() > 320 && pending_items.size() < 470;
	end

	// watchdog and end of run
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		wait (stim_done && !in_ch.valid && expected_results.size() == 0);
		repeat (500) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

FILE: files.f
src/epsc_pkg.sv
src/epsc_in_if.sv
src/epsc_out_if.sv
src/epsc_ram.sv
src/expiring_partition_share_counter_top.sv
bench/tb_top.sv
